@@ src/mmt_pkg.sv @@
// Package for the matrix multiply/transpose unit: sizes, codes, state encoding
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmt_pkg;

  // Largest matrix edge; stores hold MAX_DIM*MAX_DIM entries.
  localparam int MAX_DIM = 8;

  localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;  // position 0..MAX_DIM-1
  localparam int CNT_W   = $clog2(MAX_DIM + 1);                  // edge length 1..MAX_DIM
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int SIZE_W  = 2 * CNT_W;                            // rows*cols

  // Fixed field widths
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 16;
  localparam int POS_W      = 3;
  localparam int CFG_DIM_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam int FRAC_W     = 8;

  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = PROD_W + DIM_W;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'((1 << (VAL_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN    = -SAT_MAX - 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_START  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_ROWS  = 3'd0,
    REG_A_COLS  = 3'd1,
    REG_B_ROWS  = 3'd2,
    REG_B_COLS  = 3'd3,
    REG_TRANS_A = 3'd4,
    REG_TRANS_B = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ERROR,
    ST_ACCUM,
    ST_EMIT
  } state_e;

  // Effective (clamped) dimensions and transpose flags
  typedef struct packed {
    logic [CNT_W-1:0] a_rows;
    logic [CNT_W-1:0] a_cols;
    logic [CNT_W-1:0] b_rows;
    logic [CNT_W-1:0] b_cols;
    logic             trans_a;
    logic             trans_b;
  } dims_t;

  typedef struct packed {
    logic wr_a;         // write A store at the input index
    logic wr_b;         // write B store at the input index
    logic seq_clear;    // zero row/column/inner counters
    logic rd_en;        // read one operand pair
    logic k_step;       // advance inner counter
    logic elem_step;    // advance to next result element
    logic acc_clear;    // zero the accumulator
    logic emit_result;  // load a product element into the output register
    logic emit_error;   // load the dimension error result
  } ctrl_cmd_t;

  typedef struct packed {
    logic dims_ok;
    logic k_last;
    logic elem_last;
    logic pipe_busy;
    logic slot_free;
  } ctrl_status_t;

  // Clamp a dimension register: 0 counts as 1, above MAX_DIM counts as MAX_DIM.
  function automatic logic [CNT_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/mmt_ifs.sv @@
// Valid/ready channel interfaces for the matrix multiply/transpose unit:
// input items, result items and configuration writes. Depends on mmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mmt_in_if;
  import mmt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [IDX_W-1:0]        element_index;
  logic signed [VAL_W-1:0] element_value;

  modport source (output valid, command, element_index, element_value, input ready);
  modport sink   (input valid, command, element_index, element_value, output ready);
endinterface

interface mmt_out_if;
  import mmt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] product_value;
  logic [POS_W-1:0]        product_row;
  logic [POS_W-1:0]        product_col;
  logic                    last;
  logic                    dims_error;

  modport source (output valid, product_value, product_row, product_col, last, dims_error,
                  input ready);
  modport sink   (input valid, product_value, product_row, product_col, last, dims_error,
                  output ready);
endinterface

interface mmt_cfg_if;
  import mmt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/mmt_cfg_regs.sv @@
// Configuration register file: dimension and transpose registers with clamping.
// Depends on mmt_pkg and mmt_ifs.
`timescale 1ns / 1ps
`default_nettype none

module mmt_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  mmt_cfg_if.sink         cfg_i,
  output mmt_pkg::dims_t  dims_o
);
  import mmt_pkg::*;

  logic [CFG_DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic                 trans_a_q, trans_b_q;
  logic                 wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q  <= CFG_DIM_W'(MAX_DIM);
      a_cols_q  <= CFG_DIM_W'(MAX_DIM);
      b_rows_q  <= CFG_DIM_W'(MAX_DIM);
      b_cols_q  <= CFG_DIM_W'(MAX_DIM);
      trans_a_q <= 1'b0;
      trans_b_q <= 1'b0;
    end else if (wr) begin
      case (cfg_i.index)
        REG_A_ROWS:  a_rows_q  <= cfg_i.data;
        REG_A_COLS:  a_cols_q  <= cfg_i.data;
        REG_B_ROWS:  b_rows_q  <= cfg_i.data;
        REG_B_COLS:  b_cols_q  <= cfg_i.data;
        REG_TRANS_A: trans_a_q <= cfg_i.data[0];
        REG_TRANS_B: trans_b_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dims_o.a_rows  = eff_dim(a_rows_q);
    dims_o.a_cols  = eff_dim(a_cols_q);
    dims_o.b_rows  = eff_dim(b_rows_q);
    dims_o.b_cols  = eff_dim(b_cols_q);
    dims_o.trans_a = trans_a_q;
    dims_o.trans_b = trans_b_q;
  end

endmodule

`default_nettype wire

@@ src/mmt_ctrl.sv @@
// Controller state machine: decodes input items and sequences the
// multiply-accumulate runs. Depends on mmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            in_command_i,
  output logic                  in_ready_o,
  input  mmt_pkg::ctrl_status_t status_i,
  output mmt_pkg::ctrl_cmd_t    cmd_o
);
  import mmt_pkg::*;

  state_e state_q, state_d;
  logic   emit_ok;

  assign emit_ok = !status_i.pipe_busy && status_i.slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_command_i == CMD_START) begin
          state_d = status_i.dims_ok ? ST_ACCUM : ST_ERROR;
        end
      end
      ST_ERROR: begin
        if (status_i.slot_free) state_d = ST_IDLE;
      end
      ST_ACCUM: begin
        if (status_i.k_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_ok) state_d = status_i.elem_last ? ST_IDLE : ST_ACCUM;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_command_i)
            CMD_LOAD_A: cmd_o.wr_a = 1'b1;
            CMD_LOAD_B: cmd_o.wr_b = 1'b1;
            CMD_START: begin
              cmd_o.seq_clear = 1'b1;
              cmd_o.acc_clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_ERROR: begin
        cmd_o.emit_error = status_i.slot_free;
      end
      ST_ACCUM: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.k_step = 1'b1;
      end
      ST_EMIT: begin
        if (emit_ok) begin
          cmd_o.emit_result = 1'b1;
          cmd_o.elem_step   = !status_i.elem_last;
          cmd_o.acc_clear   = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ src/mmt_datapath.sv @@
// Datapath: operand stores, address generation, registered multiply,
// wide accumulator, rounding/saturation and the output register.
// Depends on mmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmt_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mmt_pkg::dims_t               dims_i,
  input  mmt_pkg::ctrl_cmd_t           cmd_i,
  output mmt_pkg::ctrl_status_t        status_o,
  input  logic [mmt_pkg::IDX_W-1:0]    element_index_i,
  input  logic [mmt_pkg::VAL_W-1:0]    element_value_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [mmt_pkg::VAL_W-1:0]    product_value_o,
  output logic [mmt_pkg::POS_W-1:0]    product_row_o,
  output logic [mmt_pkg::POS_W-1:0]    product_col_o,
  output logic                         last_o,
  output logic                         dims_error_o
);
  import mmt_pkg::*;

  // Operand stores
  logic [VAL_W-1:0] a_mem [DEPTH];
  logic [VAL_W-1:0] b_mem [DEPTH];

  logic [CNT_W-1:0]  m_dim, ka_dim, kb_dim, n_dim;
  logic [SIZE_W-1:0] a_size, b_size;
  logic              a_we, b_we;
  logic [ADDR_W-1:0] w_addr, a_raddr, b_raddr;
  logic [DIM_W-1:0]  a_r, a_c, b_r, b_c;
  logic [DIM_W-1:0]  i_q, j_q, k_q;
  logic              j_wrap;

  logic [VAL_W-1:0]         a_rdata_q, b_rdata_q;
  logic                     rd_vld_q, mul_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_biased, acc_shift;
  logic [VAL_W-1:0]         sat_value;

  logic                     out_valid_q;
  logic [VAL_W-1:0]         value_q;
  logic [POS_W-1:0]         row_q, col_q;
  logic                     last_q, err_q;

  // Shape of op(A) * op(B)
  assign m_dim  = dims_i.trans_a ? dims_i.a_cols : dims_i.a_rows;
  assign ka_dim = dims_i.trans_a ? dims_i.a_rows : dims_i.a_cols;
  assign kb_dim = dims_i.trans_b ? dims_i.b_cols : dims_i.b_rows;
  assign n_dim  = dims_i.trans_b ? dims_i.b_rows : dims_i.b_cols;

  // Loads beyond the stored matrix are dropped
  assign a_size = SIZE_W'(dims_i.a_rows) * SIZE_W'(dims_i.a_cols);
  assign b_size = SIZE_W'(dims_i.b_rows) * SIZE_W'(dims_i.b_cols);
  assign a_we   = cmd_i.wr_a && (element_index_i < a_size);
  assign b_we   = cmd_i.wr_b && (element_index_i < b_size);
  assign w_addr = ADDR_W'(element_index_i);

  // Stored coordinates of the current operand pair
  assign a_r = dims_i.trans_a ? k_q : i_q;
  assign a_c = dims_i.trans_a ? i_q : k_q;
  assign b_r = dims_i.trans_b ? j_q : k_q;
  assign b_c = dims_i.trans_b ? k_q : j_q;
  assign a_raddr = ADDR_W'(ADDR_W'(a_r) * ADDR_W'(dims_i.a_cols) + ADDR_W'(a_c));
  assign b_raddr = ADDR_W'(ADDR_W'(b_r) * ADDR_W'(dims_i.b_cols) + ADDR_W'(b_c));

  assign j_wrap = (CNT_W'(j_q) + CNT_W'(1)) == n_dim;

  always_ff @(posedge clk_i) begin
    if (a_we) a_mem[w_addr] <= element_value_i;
    if (cmd_i.rd_en) a_rdata_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) b_mem[w_addr] <= element_value_i;
    if (cmd_i.rd_en) b_rdata_q <= b_mem[b_raddr];
  end

  // Loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (cmd_i.seq_clear) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (cmd_i.elem_step) begin
      k_q <= '0;
      if (j_wrap) begin
        j_q <= '0;
        i_q <= i_q + DIM_W'(1);
      end else begin
        j_q <= j_q + DIM_W'(1);
      end
    end else if (cmd_i.k_step) begin
      k_q <= k_q + DIM_W'(1);
    end
  end

  // Read, multiply and accumulate stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.rd_en;
      mul_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) prod_q <= signed'(a_rdata_q) * signed'(b_rdata_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clear) begin
      acc_q <= '0;
    end else if (mul_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Round to nearest (ties up), then saturate to Q8.8
  assign acc_biased = acc_q + ROUND_BIAS;
  assign acc_shift  = acc_biased >>> FRAC_W;

  always_comb begin
    if (acc_shift > SAT_MAX) begin
      sat_value = SAT_MAX[VAL_W-1:0];
    end else if (acc_shift < SAT_MIN) begin
      sat_value = SAT_MIN[VAL_W-1:0];
    end else begin
      sat_value = acc_shift[VAL_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_result || cmd_i.emit_error) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_error) begin
      value_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
      last_q  <= 1'b1;
      err_q   <= 1'b1;
    end else if (cmd_i.emit_result) begin
      value_q <= sat_value;
      row_q   <= POS_W'(i_q);
      col_q   <= POS_W'(j_q);
      last_q  <= status_o.elem_last;
      err_q   <= 1'b0;
    end
  end

  always_comb begin
    status_o.dims_ok   = (ka_dim == kb_dim);
    status_o.k_last    = (CNT_W'(k_q) + CNT_W'(1)) == ka_dim;
    status_o.elem_last = ((CNT_W'(i_q) + CNT_W'(1)) == m_dim) && j_wrap;
    status_o.pipe_busy = rd_vld_q || mul_vld_q;
    status_o.slot_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o     = out_valid_q;
  assign product_value_o = value_q;
  assign product_row_o   = row_q;
  assign product_col_o   = col_q;
  assign last_o          = last_q;
  assign dims_error_o    = err_q;

endmodule

`default_nettype wire

@@ src/matrix_multiply_transpose_unit.sv @@
// Top level of the matrix multiply/transpose unit: configuration registers,
// controller and datapath. Depends on mmt_pkg, mmt_ifs and the three submodules.
`timescale 1ns / 1ps
`default_nettype none

// Computes op(A) * op(B) on signed Q8.8 matrices of up to MAX_DIM x MAX_DIM,
// where op() optionally transposes its operand. Load items write one element
// of A or B (row-major index of the stored layout) and are accepted back to
// back while no run is in progress; loads past rows*cols are dropped. A start
// item checks the inner dimensions: on a mismatch it returns a single result
// flagged dims_error and last; otherwise it streams every product element in
// row-major order, last set on the final one. Each element is summed exactly
// in a wide accumulator, then rounded to nearest (ties up) and saturated to
// Q8.8. One multiplier is shared by all elements: for each element the stores
// are read one operand pair per cycle (K = inner dimension, up to MAX_DIM
// pairs) into the registered multiplier and accumulator, and the element is
// emitted once that pipeline has drained. Input is held off for the whole run.
// Results sit in an output register, so the block keeps computing while a
// result waits to be transferred and stalls only when the next one is ready.
// Configuration may be written only while no run is in progress.
module matrix_multiply_transpose_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmt_in_if.sink     in_i,
  mmt_out_if.source  out_o,
  mmt_cfg_if.sink    cfg_i
);
  import mmt_pkg::*;

  dims_t        dims;
  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Clamped dimensions and transpose flags
  mmt_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .dims_o (dims)
  );

  // Sequencer: decode items, step through elements and inner products
  mmt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // Stores, multiply-accumulate and output register
  mmt_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dims_i          (dims),
    .cmd_i           (cmd),
    .status_o        (status),
    .element_index_i (in_i.element_index),
    .element_value_i (in_i.element_value),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .product_value_o (out_o.product_value),
    .product_row_o   (out_o.product_row),
    .product_col_o   (out_o.product_col),
    .last_o          (out_o.last),
    .dims_error_o    (out_o.dims_error)
  );

endmodule

`default_nettype wire

@@ src/mmt_checker.sv @@
// Port-level checker for the matrix multiply/transpose unit, bound to the top
// level. Depends on mmt_pkg and matrix_multiply_transpose_unit.
`timescale 1ns / 1ps
`default_nettype none

module mmt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_command_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_value_i,
  input logic [2:0]  out_row_i,
  input logic [2:0]  out_col_i,
  input logic        out_last_i,
  input logic        out_error_i
);
  import mmt_pkg::*;

  // An error result is a lone, zeroed, final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_error_i |->
      out_last_i && out_value_i == '0 && out_row_i == '0 && out_col_i == '0)
    else $error("dims error result not zeroed or not last");

  // A start transfer begins a run: input is held off next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_command_i == CMD_START |=> !in_ready_i)
    else $error("input accepted right after a start");

  // While a non-final result waits, the run is still going
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input accepted in the middle of a run");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_value_i) && $stable(out_row_i) && $stable(out_col_i)
      && $stable(out_last_i) && $stable(out_error_i))
    else $error("stalled result changed");

endmodule

bind matrix_multiply_transpose_unit mmt_checker u_mmt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_value_i  (out_o.product_value),
  .out_row_i    (out_o.product_row),
  .out_col_i    (out_o.product_col),
  .out_last_i   (out_o.last),
  .out_error_i  (out_o.dims_error)
);

`default_nettype wire
